// ----- hw/rtl/vht_pkg.sv -----
// Package for the volume hysteresis trigger with moving mean.
// Item kinds, register addresses, reset values and the sequencer state type.
// No dependencies.
package vht_pkg;

  localparam int unsigned VOL_W  = 16;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned QUO_W  = 16;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // item kinds carried in tuser
  localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  // register map
  localparam logic [PADDR_W-1:0] ADDR_TRIG_IN  = 4'h0;
  localparam logic [PADDR_W-1:0] ADDR_TRIG_OUT = 4'h4;
  localparam logic [PADDR_W-1:0] ADDR_WIN_LEN  = 4'h8;

  localparam logic [VOL_W-1:0] TRIG_IN_RST  = 16'd19661;
  localparam logic [VOL_W-1:0] TRIG_OUT_RST = 16'd6554;
  localparam logic [LEN_W-1:0] WIN_LEN_RST  = 10'd300;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_START,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ----- hw/rtl/vht_div.sv -----
// Serial restoring divider for the window mean, one quotient bit per cycle.
// Depends on vht_pkg.
module vht_div #(
  parameter int unsigned DIV_W = 26,
  parameter int unsigned CNT_W = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DIV_W-1:0]            dividend_i,
  input  logic [CNT_W-1:0]            divisor_i,
  output logic                        done_o,
  output logic [vht_pkg::QUO_W-1:0]   quotient_o
);
  import vht_pkg::*;

  localparam int unsigned STEP_W = $clog2(QUO_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q, dvs_q, rem_d;
  logic [QUO_W-1:0]  quo_q;
  logic [CNT_W:0]    trial;
  logic              ge;

  // dividend < divisor * 2^16, so the upper part starts below the divisor
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign ge    = trial >= (CNT_W+1)'(dvs_q);
  assign rem_d = ge ? CNT_W'(trial - (CNT_W+1)'(dvs_q)) : CNT_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == STEP_W'(QUO_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(QUO_W - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= CNT_W'(dividend_i >> QUO_W);
      quo_q <= dividend_i[QUO_W-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/volume_hysteresis_trigger_mean_top.sv -----
// Volume hysteresis trigger with a moving-window mean.
// Sequence: a sample beat passes ring update, divider load, 16 divider steps, mean capture
//   and result load before its result is valid; tick and restart beats go straight to result load.
// Flow: one beat at a time; the next beat is accepted only once the result register is loaded,
//   which waits while the result register is full and m_axis_tready is low.
// Reset (async, active low) clears window, detector and output valid; ring is not cleared.
module volume_hysteresis_trigger_mean_top #(
  parameter int unsigned WINDOW_MAX = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // volume[15:0], elapsed[31:16]
  input  logic [1:0]                    s_axis_tuser,  // func[1:0]
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // triggered[0], inside_wave[1], window_mean[17:2], accumulated[49:18],
  // state_time[81:50], zero pad[87:82]
  output logic [87:0]                   m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vht_pkg::PADDR_W-1:0]   paddr,
  input  logic [vht_pkg::PDATA_W-1:0]   pwdata,
  output logic [vht_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import vht_pkg::*;

  localparam int unsigned LEN_MAX = (WINDOW_MAX < 1023) ? WINDOW_MAX : 1023;
  localparam int unsigned PTR_W   = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W   = $clog2(LEN_MAX + 1);
  localparam int unsigned SUM_W   = $clog2(LEN_MAX * 65535 + 1);
  localparam int unsigned DIV_W   = SUM_W + 1;
  localparam int unsigned CMP_W   = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  state_e state_q, state_d;

  logic [VOL_W-1:0] trig_in_q, trig_out_q;
  logic [LEN_W-1:0] win_len_q, len_eff;
  logic             cfg_wr;

  logic [PTR_W-1:0] ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] sum_q;
  logic [VOL_W-1:0] mean_q;
  logic             inside_q, trig_q;
  logic [ACC_W-1:0] acc_q, time_q;

  logic [1:0]       func_in;
  logic [VOL_W-1:0] vol_in, ela_in, vol_q, rd_q;
  logic             in_acc, is_sample;

  logic             full;
  logic [CMP_W-1:0] ptr_inc;
  logic             ring_we, div_start, div_done, out_load;
  logic [QUO_W-1:0] quotient;

  logic [VOL_W-1:0] ring_q [WINDOW_MAX];

  logic             out_valid_q;
  logic [87:0]      out_data_q;

  assign func_in   = s_axis_tuser;
  assign vol_in    = s_axis_tdata[15:0];
  assign ela_in    = s_axis_tdata[31:16];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign is_sample = (func_in == FUNC_SAMPLE);

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (win_len_q == '0) len_eff = LEN_W'(1);
    else if (32'(win_len_q) > LEN_MAX) len_eff = LEN_W'(LEN_MAX);
    else len_eff = win_len_q;
  end

  always_comb begin
    unique case (paddr)
      ADDR_TRIG_IN:  prdata = PDATA_W'(trig_in_q);
      ADDR_TRIG_OUT: prdata = PDATA_W'(trig_out_q);
      ADDR_WIN_LEN:  prdata = PDATA_W'(win_len_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_in_q  <= TRIG_IN_RST;
      trig_out_q <= TRIG_OUT_RST;
      win_len_q  <= WIN_LEN_RST;
    end else if (cfg_wr) begin
      if (paddr == ADDR_TRIG_IN)  trig_in_q  <= pwdata[VOL_W-1:0];
      if (paddr == ADDR_TRIG_OUT) trig_out_q <= pwdata[VOL_W-1:0];
      if (paddr == ADDR_WIN_LEN)  win_len_q  <= pwdata[LEN_W-1:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_acc) state_d = is_sample ? ST_UPDATE : ST_DONE;
      ST_UPDATE:    state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV;
      ST_DIV:       if (div_done) state_d = ST_DONE;
      ST_DONE:      if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ring_we       = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE:      s_axis_tready = 1'b1;
      ST_UPDATE:    ring_we = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      ST_DIV:       ;
      ST_DONE:      out_load = !out_valid_q || m_axis_tready;
      default:      ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // ---------------- window ring ----------------
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_q[ptr_q] <= vol_q;
    if (in_acc)  rd_q <= ring_q[ptr_q];   // oldest entry, used once the window is full
  end

  assign full    = LEN_W'(cnt_q) >= len_eff;
  assign ptr_inc = CMP_W'(ptr_q) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      mean_q <= '0;
    end else begin
      if (cfg_wr && paddr == ADDR_WIN_LEN) begin
        ptr_q <= '0;
        cnt_q <= '0;
        sum_q <= '0;
      end else if (ring_we) begin
        if (full) sum_q <= sum_q - SUM_W'(rd_q) + SUM_W'(vol_q);
        else begin
          sum_q <= sum_q + SUM_W'(vol_q);
          cnt_q <= cnt_q + 1'b1;
        end
        ptr_q <= (ptr_inc >= CMP_W'(len_eff)) ? '0 : PTR_W'(ptr_inc);
      end
      if (state_q == ST_DIV && div_done) mean_q <= quotient;
    end
  end

  // mean = (sum + count/2) / count, round half up
  vht_div #(
    .DIV_W (DIV_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_W'(sum_q) + DIV_W'(cnt_q >> 1)),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // ---------------- hysteresis detector ----------------
  logic [ACC_W:0] acc_add, time_add;
  assign acc_add  = (ACC_W+1)'(acc_q) + (ACC_W+1)'(vol_in);
  assign time_add = (ACC_W+1)'(time_q) + (ACC_W+1)'(ela_in);

  always_ff @(posedge clk_i) begin
    if (in_acc) vol_q <= vol_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      trig_q   <= 1'b0;
      acc_q    <= '0;
      time_q   <= '0;
    end else if (in_acc) begin
      trig_q <= 1'b0;
      case (func_in)
        FUNC_SAMPLE: begin
          if (inside_q) begin
            if (vol_in <= trig_out_q) begin
              inside_q <= 1'b0;
              time_q   <= '0;
            end
          end else if (vol_in >= trig_in_q) begin
            trig_q   <= 1'b1;
            inside_q <= 1'b1;
            acc_q    <= '0;
            time_q   <= '0;
          end else begin
            acc_q <= acc_add[ACC_W] ? '1 : acc_add[ACC_W-1:0];
          end
        end
        FUNC_TICK:    time_q <= time_add[ACC_W] ? '1 : time_add[ACC_W-1:0];
        FUNC_RESTART: begin
          inside_q <= 1'b0;
          acc_q    <= '0;
          time_q   <= '0;
        end
        default: ;
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (m_axis_tready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= {6'b0, time_q, acc_q, mean_q, inside_q, trig_q};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------- assertions ----------------
  a_cnt_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(cnt_q) <= len_eff)
    else $error("window count beyond window length");

  a_ptr_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(ptr_q) < CMP_W'(len_eff))
    else $error("ring pointer beyond window length");

  a_trig_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("trigger reported outside a wave");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_START |=> !div_done)
    else $error("divider finished too early");

endmodule

// ----- bench/volume_hysteresis_trigger_mean_top_tb.sv -----
// Self-checking bench for volume_hysteresis_trigger_mean_top: random and directed beats
// on the input stream, results checked against an in-bench model of the meter and detector.
// Depends on vht_pkg and the RTL of the block.
module volume_hysteresis_trigger_mean_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vht_pkg::*;

  localparam int unsigned WIN_CAP      = 512;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned SHOWN_ERRORS = 10;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam logic [31:0] SAT_MAX      = 32'hFFFF_FFFF;

  typedef struct {
    logic [1:0]       func;
    logic [VOL_W-1:0] volume;
    logic [15:0]      elapsed;
  } vol_beat_t;

  // same bit order as m_axis_tdata[81:0]
  typedef struct packed {
    logic [31:0]      state_time;
    logic [31:0]      accumulated;
    logic [VOL_W-1:0] window_mean;
    logic             inside_wave;
    logic             triggered;
  } level_rec_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata = '0;   // volume[15:0], elapsed[31:16]
  logic [1:0]         s_axis_tuser = '0;   // func[1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // triggered[0], inside_wave[1], window_mean[17:2], accumulated[49:18],
  // state_time[81:50], zero pad[87:82]
  logic [87:0]        m_axis_tdata;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  volume_hysteresis_trigger_mean_top #(
    .WINDOW_MAX(WIN_CAP)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model state
  logic [VOL_W-1:0] ring_m [WIN_CAP];
  int unsigned      wr_m, fill_m, sum_m, win_m;
  logic [VOL_W-1:0] mean_m;
  logic             inside_m;
  logic [31:0]      acc_m, time_m;
  logic [VOL_W-1:0] trig_in_m, trig_out_m;

  vol_beat_t   beats_pending [$];
  level_rec_t  level_expect [$];
  int unsigned beats_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned fail_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  logic        in_beat_taken = 1'b0;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT_MAX : s[31:0];
  endfunction

  function level_rec_t advance_meter(input vol_beat_t b);
    level_rec_t r;
    r = '0;
    case (b.func)
      FUNC_SAMPLE: begin
        if (fill_m >= win_m) begin
          sum_m = sum_m - ring_m[wr_m];
        end else begin
          fill_m = fill_m + 1;
        end
        ring_m[wr_m] = b.volume;
        sum_m = sum_m + b.volume;
        wr_m = (wr_m + 1 >= win_m) ? 0 : wr_m + 1;
        mean_m = VOL_W'((sum_m + fill_m / 2) / fill_m);
        if (inside_m) begin
          if (b.volume <= trig_out_m) begin
            inside_m = 1'b0;
            time_m = '0;
          end
        end else begin
          acc_m = sat_add(acc_m, 32'(b.volume));
          if (b.volume >= trig_in_m) begin
            r.triggered = 1'b1;
            inside_m = 1'b1;
            acc_m = '0;
            time_m = '0;
          end
        end
      end
      FUNC_TICK: time_m = sat_add(time_m, 32'(b.elapsed));
      FUNC_RESTART: begin
        inside_m = 1'b0;
        acc_m = '0;
        time_m = '0;
      end
      default: ;
    endcase
    r.inside_wave = inside_m;
    r.window_mean = mean_m;
    r.accumulated = acc_m;
    r.state_time  = time_m;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(negedge clk_i) begin : drive
    vol_beat_t b;
    if (!s_axis_tvalid || in_beat_taken) begin
      if (rst_ni && beats_pending.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        b = beats_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.elapsed, b.volume};
        s_axis_tuser  <= b.func;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin : observe
    vol_beat_t  b;
    level_rec_t want, got;
    in_beat_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      b.func    = s_axis_tuser;
      b.volume  = s_axis_tdata[15:0];
      b.elapsed = s_axis_tdata[31:16];
      level_expect.push_back(advance_meter(b));
      beats_taken <= beats_taken + 1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[81:0];
      if (level_expect.size() == 0) begin
        if (fail_count < SHOWN_ERRORS)
          $display("unexpected result beat: %h", m_axis_tdata);
        fail_count = fail_count + 1;
      end else begin
        want = level_expect.pop_front();
        if (got !== want || m_axis_tdata[87:82] !== '0) begin
          if (fail_count < SHOWN_ERRORS)
            $display("mismatch exp %0d %0d %0d %0d %0d | got %0d %0d %0d %0d %0d pad %h",
                     want.triggered, want.inside_wave, want.window_mean,
                     want.accumulated, want.state_time,
                     got.triggered, got.inside_wave, got.window_mean,
                     got.accumulated, got.state_time, m_axis_tdata[87:82]);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic queue_beat(input logic [1:0] f, input logic [15:0] v, input logic [15:0] e);
    vol_beat_t b;
    b.func    = f;
    b.volume  = v;
    b.elapsed = e;
    beats_pending.push_back(b);
    beats_queued = beats_queued + 1;
  endtask

  task automatic wait_drained();
    while (beats_taken != beats_queued || level_expect.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      ADDR_TRIG_IN:  trig_in_m = value[15:0];
      ADDR_TRIG_OUT: trig_out_m = value[15:0];
      ADDR_WIN_LEN: begin
        // 0 behaves as 1, anything above the ring size as the ring size
        win_m  = (value[9:0] == 0) ? 1 : ((value[9:0] > WIN_CAP) ? WIN_CAP : value[9:0]);
        wr_m   = 0;
        fill_m = 0;
        sum_m  = 0;
      end
      default: ;
    endcase
  endtask

  // biased towards the thresholds so the detector keeps changing state
  function automatic vol_beat_t random_beat();
    vol_beat_t   b;
    int unsigned pick;
    int          near;
    b.volume  = VOL_W'($urandom);
    b.elapsed = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      b.func = FUNC_SAMPLE;
      case ($urandom_range(0, 9))
        0: b.volume = '0;
        1: b.volume = '1;
        2, 3: begin
          near = int'(trig_in_m) + int'($urandom_range(0, 4)) - 2;
          b.volume = VOL_W'((near < 0) ? 0 : ((near > 65535) ? 65535 : near));
        end
        4, 5: begin
          near = int'(trig_out_m) + int'($urandom_range(0, 4)) - 2;
          b.volume = VOL_W'((near < 0) ? 0 : ((near > 65535) ? 65535 : near));
        end
        default: ;
      endcase
    end else if (pick < 85) begin
      b.func = FUNC_TICK;
      if ($urandom_range(0, 7) == 0) b.elapsed = '1;
    end else if (pick < 93) begin
      b.func = FUNC_RESTART;
    end else begin
      b.func = FUNC_UNUSED;
    end
    return b;
  endfunction

  initial begin : main
    int unsigned blk_in [6];
    int unsigned blk_out [6];
    int unsigned blk_len [6];
    int unsigned blk_items [6];
    vol_beat_t   b;

    wr_m       = 0;
    fill_m     = 0;
    sum_m      = 0;
    win_m      = WIN_LEN_RST;
    mean_m     = '0;
    inside_m   = 1'b0;
    acc_m      = '0;
    time_m     = '0;
    trig_in_m  = TRIG_IN_RST;
    trig_out_m = TRIG_OUT_RST;

    blk_in    = '{40000, 0, 65535, $urandom_range(0, 65535), $urandom_range(0, 65535), 19661};
    blk_out   = '{10000, 65535, 0, $urandom_range(0, 65535), $urandom_range(0, 65535), 6554};
    blk_len   = '{5, 0, 1023, $urandom_range(1, 40), 513, 200};
    blk_items = '{80, 80, 80, 80, 80, 340};

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 6;
    snk_idle_pct = 77;

    // directed, on the reset settings
    queue_beat(FUNC_SAMPLE, 16'd0, 16'hFFFF);
    queue_beat(FUNC_SAMPLE, 16'd1, 16'h0000);      // mean of 0 and 1 rounds half up
    queue_beat(FUNC_TICK, 16'hFFFF, 16'd0);
    queue_beat(FUNC_TICK, 16'h0000, 16'hFFFF);
    queue_beat(FUNC_SAMPLE, 16'd19660, 16'd7);      // just under the enter level
    queue_beat(FUNC_SAMPLE, 16'd19661, 16'd0);      // exactly on it: wave starts
    queue_beat(FUNC_SAMPLE, 16'hFFFF, 16'd0);
    queue_beat(FUNC_SAMPLE, 16'd6555, 16'd0);       // just above the leave level
    queue_beat(FUNC_TICK, 16'd0, 16'd1);
    queue_beat(FUNC_SAMPLE, 16'd6554, 16'd0);       // exactly on it: wave ends
    queue_beat(FUNC_SAMPLE, 16'hFFFF, 16'hFFFF);
    queue_beat(FUNC_RESTART, 16'hFFFF, 16'hFFFF);
    queue_beat(FUNC_UNUSED, 16'hFFFF, 16'hFFFF);
    queue_beat(FUNC_SAMPLE, 16'd0, 16'd0);
    queue_beat(FUNC_TICK, 16'd0, 16'hFFFF);
    queue_beat(FUNC_SAMPLE, 16'd30000, 16'd0);
    queue_beat(FUNC_UNUSED, 16'h0000, 16'h0000);
    queue_beat(FUNC_TICK, 16'd0, 16'd123);
    queue_beat(FUNC_RESTART, 16'h0000, 16'h0000);
    queue_beat(FUNC_SAMPLE, 16'hFFFF, 16'd0);
    queue_beat(FUNC_SAMPLE, 16'd0, 16'd0);
    wait_drained();

    for (int blk = 0; blk < 6; blk++) begin
      if (blk < 2) begin
        src_idle_pct = 6;
        snk_idle_pct = 77;
      end else if (blk < 4) begin
        src_idle_pct = 77;
        snk_idle_pct = 6;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      write_reg(ADDR_TRIG_IN, blk_in[blk]);
      write_reg(ADDR_TRIG_OUT, blk_out[blk]);
      write_reg(ADDR_WIN_LEN, blk_len[blk]);
      // a tick first: the held mean must survive the window clear
      queue_beat(FUNC_TICK, VOL_W'($urandom), 16'($urandom));
      for (int n = 0; n < blk_items[blk]; n++) begin
        if (n == blk_items[blk] / 2) wait_drained();
        b = random_beat();
        queue_beat(b.func, b.volume, b.elapsed);
      end
      wait_drained();
    end

    repeat (30) @(negedge clk_i);
    if (fail_count == 0 && level_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
